[src/gtf_pkg.sv]
// Shared definitions for the glyph text framebuffer: store geometry, command
// and register codes, the 5x7 font table and the store address helper.
// No dependencies.
`default_nettype none

package gtf_pkg;

  // Store geometry.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_PAGES  = 8;
  localparam int FB_DEPTH   = MAX_PAGES * MAX_WIDTH;
  localparam int FB_ADDR_W  = $clog2(FB_DEPTH);
  localparam int VP_W       = $clog2(MAX_PAGES + 1);

  // Command codes.
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_GLYPH = 3'd2;
  localparam logic [2:0] CMD_TEXT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // Glyph geometry.
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
  localparam logic [7:0] TEXT_ADVANCE   = 8'd6;
  localparam logic [7:0] LINE_ADVANCE   = 8'd8;
  localparam logic [7:0] CODE_FIRST     = 8'd32;
  localparam logic [7:0] CODE_LAST      = 8'd127;
  localparam logic [7:0] CODE_FALLBACK  = 8'd63;

  typedef logic [FB_ADDR_W-1:0] fb_addr_t;

  // Byte address of (page, column); the caller keeps page below MAX_PAGES.
  function automatic fb_addr_t fb_addr(input logic [5:0] page, input logic [7:0] col);
    fb_addr = FB_ADDR_W'(int'(page) * MAX_WIDTH + int'(col));
  endfunction

  // One font column: bit r is row r of the glyph.
  function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
    logic [7:0]  c;
    logic [6:0]  g;
    logic [39:0] row;
    logic [7:0]  res;
    c = (code < CODE_FIRST || code > CODE_LAST) ? CODE_FALLBACK : code;
    g = 7'(c - CODE_FIRST);
    unique case (g)
      7'd0:  row = 40'h0000000000;  7'd1:  row = 40'h00005F0000;
      7'd2:  row = 40'h0007000700;  7'd3:  row = 40'h147F147F14;
      7'd4:  row = 40'h242A7F2A12;  7'd5:  row = 40'h2313086462;
      7'd6:  row = 40'h3649552250;  7'd7:  row = 40'h0005030000;
      7'd8:  row = 40'h001C224100;  7'd9:  row = 40'h0041221C00;
      7'd10: row = 40'h14083E0814;  7'd11: row = 40'h08083E0808;
      7'd12: row = 40'h0050300000;  7'd13: row = 40'h0808080808;
      7'd14: row = 40'h0060600000;  7'd15: row = 40'h2010080402;
      7'd16: row = 40'h3E5149453E;  7'd17: row = 40'h00427F4000;
      7'd18: row = 40'h4261514946;  7'd19: row = 40'h2141454B31;
      7'd20: row = 40'h1814127F10;  7'd21: row = 40'h2745454539;
      7'd22: row = 40'h3C4A494930;  7'd23: row = 40'h0171090503;
      7'd24: row = 40'h3649494936;  7'd25: row = 40'h064949291E;
      7'd26: row = 40'h0036360000;  7'd27: row = 40'h0056360000;
      7'd28: row = 40'h0814224100;  7'd29: row = 40'h1414141414;
      7'd30: row = 40'h0041221408;  7'd31: row = 40'h0201510906;
      7'd32: row = 40'h324979413E;  7'd33: row = 40'h7E1111117E;
      7'd34: row = 40'h7F49494936;  7'd35: row = 40'h3E41414122;
      7'd36: row = 40'h7F4141221C;  7'd37: row = 40'h7F49494941;
      7'd38: row = 40'h7F09090901;  7'd39: row = 40'h3E4149497A;
      7'd40: row = 40'h7F0808087F;  7'd41: row = 40'h00417F4100;
      7'd42: row = 40'h2040413F01;  7'd43: row = 40'h7F08142241;
      7'd44: row = 40'h7F40404040;  7'd45: row = 40'h7F020C027F;
      7'd46: row = 40'h7F0408107F;  7'd47: row = 40'h3E4141413E;
      7'd48: row = 40'h7F09090906;  7'd49: row = 40'h3E4151215E;
      7'd50: row = 40'h7F09192946;  7'd51: row = 40'h4649494931;
      7'd52: row = 40'h01017F0101;  7'd53: row = 40'h3F4040403F;
      7'd54: row = 40'h1F2040201F;  7'd55: row = 40'h3F4038403F;
      7'd56: row = 40'h6314081463;  7'd57: row = 40'h0708700807;
      7'd58: row = 40'h6151494543;  7'd59: row = 40'h007F414100;
      7'd60: row = 40'h0204081020;  7'd61: row = 40'h0041417F00;
      7'd62: row = 40'h0402010204;  7'd63: row = 40'h4040404040;
      default: row = 40'h0000000000;
    endcase
    unique case (col)
      3'd0:    res = row[39:32];
      3'd1:    res = row[31:24];
      3'd2:    res = row[23:16];
      3'd3:    res = row[15:8];
      3'd4:    res = row[7:0];
      default: res = 8'h00;
    endcase
    glyph_column = res;
  endfunction

endpackage

`default_nettype wire

[src/gtf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/glyph_text_framebuffer_unit.sv]
// Top level of the glyph text framebuffer: command sequencer, font lookup and
// read-modify-write path around one framebuffer RAM.
// Depends on gtf_pkg and gtf_ram.
`default_nettype none

// A command transaction is taken when start is high and busy is low; exactly
// one result transaction follows on out_valid, high for a single cycle, and
// the receiver cannot hold it off. All work goes through one framebuffer RAM
// with one read and one write port; each drawn glyph or pixel byte is read
// and then written back. After reset the block runs a clearing pass over all
// 1024 bytes with busy high; configuration writes are accepted then too. A
// glyph or text character walks its ten candidate bytes (5 columns by 2
// pages), skipping each byte outside the visible area or with an empty mask
// and reading and writing back the rest; a pixel walks its two candidate
// bytes the same way; an in-range read fetches one byte; a dropped text
// character or an unused command goes straight to the result; clear writes
// visible pages times visible columns.

module glyph_text_framebuffer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Command channel.
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_command,
  input  wire logic [7:0] in_x_pos,
  input  wire logic [7:0] in_y_pos,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_pixel_on,
  input  wire logic       in_text_start,
  input  wire logic [2:0] in_read_page,
  input  wire logic [6:0] in_read_column,
  // Result channel.
  output logic            out_valid,
  output logic [7:0]      out_read_data,
  output logic            out_text_stopped,
  // Configuration port.
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] ST_INIT  = 3'd0;  // clearing pass after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;  // zero the visible area
  localparam logic [2:0] ST_GSEL  = 3'd3;  // pick a glyph byte, issue its read
  localparam logic [2:0] ST_GWR   = 3'd4;  // merge the mask and write back
  localparam logic [2:0] ST_RDD   = 3'd5;  // read data arrives
  localparam logic [2:0] ST_DONE  = 3'd6;  // cursor update and result

  localparam int VP_W = gtf_pkg::VP_W;

  logic [2:0]               state_r, state_nxt;
  logic [7:0]               width_r, width_nxt;
  logic [3:0]               height_r, height_nxt;
  logic [7:0]               cursor_x_r, cursor_x_nxt;
  logic [7:0]               cursor_y_r, cursor_y_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [2:0]               cmd_r, cmd_nxt;
  logic [7:0]               x_r, x_nxt;
  logic [7:0]               y_r, y_nxt;
  logic [7:0]               code_r, code_nxt;
  logic                     on_r, on_nxt;
  logic                     pix_r, pix_nxt;
  logic [2:0]               col_r, col_nxt;
  logic                     half_r, half_nxt;
  logic [7:0]               mask_r, mask_nxt;
  gtf_pkg::fb_addr_t        addr_r, addr_nxt;
  logic [7:0]               cl_col_r, cl_col_nxt;
  logic [VP_W-1:0]          cl_pg_r, cl_pg_nxt;
  gtf_pkg::fb_addr_t        init_addr_r, init_addr_nxt;
  logic [7:0]               rd_r, rd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_read_data_r, out_read_data_nxt;
  logic                     out_text_stopped_r, out_text_stopped_nxt;

  // Visible area after clamping oversized registers.
  logic [7:0]               vis_w;
  logic [VP_W-1:0]          vis_p;

  // Glyph byte selection.
  logic [7:0]               g_cx;
  logic [7:0]               g_line;
  logic [15:0]              g_wide;
  logic [7:0]               g_mask;
  logic [4:0]               g_pg;
  logic                     g_vis;
  logic                     g_last;
  gtf_pkg::fb_addr_t        g_addr;

  // Cursor advance.
  logic [7:0]               t_nx;
  logic [7:0]               t_ny;
  logic                     t_wrap;

  logic                     accept;
  logic                     rd_in_range;

  // RAM ports.
  logic                     ram_we;
  gtf_pkg::fb_addr_t        ram_waddr;
  logic [7:0]               ram_wdata;
  logic                     ram_re;
  gtf_pkg::fb_addr_t        ram_raddr;
  logic [7:0]               ram_rdata;

  gtf_ram #(
    .WIDTH(8),
    .DEPTH(gtf_pkg::FB_DEPTH)
  ) u_fb_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign vis_w = (int'(width_r) > gtf_pkg::MAX_WIDTH) ? 8'(gtf_pkg::MAX_WIDTH) : width_r;
  assign vis_p = (int'(height_r) > gtf_pkg::MAX_PAGES) ? VP_W'(gtf_pkg::MAX_PAGES)
                                                       : VP_W'(height_r);

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign rd_in_range = (int'(in_read_page) < gtf_pkg::MAX_PAGES) &&
                       (int'(in_read_column) < gtf_pkg::MAX_WIDTH);

  // The font column is shifted by the row offset inside the page; the low byte
  // lands in the first page and the spill in the next one. Page numbers wrap
  // with the row coordinate, so page 31 is followed by page 0.
  assign g_cx   = x_r + 8'(col_r);
  assign g_line = pix_r ? 8'h01 : gtf_pkg::glyph_column(code_r, col_r);
  assign g_wide = 16'(g_line) << y_r[2:0];
  assign g_mask = half_r ? g_wide[15:8] : g_wide[7:0];
  assign g_pg   = y_r[7:3] + 5'(half_r);
  assign g_vis  = (g_cx < vis_w) && (6'(g_pg) < 6'(vis_p)) && (g_mask != 8'h00);
  assign g_last = half_r && (col_r == (pix_r ? 3'd0 : gtf_pkg::GLYPH_LAST_COL));
  assign g_addr = gtf_pkg::fb_addr(6'(g_pg), g_cx);

  // The cursor steps one glyph cell to the right and wraps to the next text
  // line when the following glyph would reach the last visible column.
  assign t_nx   = x_r + gtf_pkg::TEXT_ADVANCE;
  assign t_wrap = (9'(t_nx) + 9'd5) >= 9'(vis_w);
  assign t_ny   = t_wrap ? (y_r + gtf_pkg::LINE_ADVANCE) : y_r;

  always_comb begin
    state_nxt            = state_r;
    width_nxt            = width_r;
    height_nxt           = height_r;
    cursor_x_nxt         = cursor_x_r;
    cursor_y_nxt         = cursor_y_r;
    dropped_nxt          = dropped_r;
    cmd_nxt              = cmd_r;
    x_nxt                = x_r;
    y_nxt                = y_r;
    code_nxt             = code_r;
    on_nxt               = on_r;
    pix_nxt              = pix_r;
    col_nxt              = col_r;
    half_nxt             = half_r;
    mask_nxt             = mask_r;
    addr_nxt             = addr_r;
    cl_col_nxt           = cl_col_r;
    cl_pg_nxt            = cl_pg_r;
    init_addr_nxt        = init_addr_r;
    rd_nxt               = rd_r;
    out_valid_nxt        = 1'b0;
    out_read_data_nxt    = out_read_data_r;
    out_text_stopped_nxt = out_text_stopped_r;
    ram_we               = 1'b0;
    ram_waddr            = addr_r;
    ram_wdata            = 8'h00;
    ram_re               = 1'b0;
    ram_raddr            = g_addr;

    // Configuration writes are taken in any state.
    if (cfg_we) begin
      unique case (cfg_index)
        gtf_pkg::REG_WIDTH:  width_nxt  = cfg_wdata;
        gtf_pkg::REG_HEIGHT: height_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_INIT: begin
        ram_we        = 1'b1;
        ram_waddr     = init_addr_r;
        init_addr_nxt = init_addr_r + 1'b1;
        if (init_addr_r == gtf_pkg::FB_ADDR_W'(gtf_pkg::FB_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_command;
          x_nxt      = in_x_pos;
          y_nxt      = in_y_pos;
          code_nxt   = in_char_code;
          on_nxt     = in_pixel_on;
          pix_nxt    = (in_command == gtf_pkg::CMD_PIXEL);
          col_nxt    = 3'd0;
          half_nxt   = 1'b0;
          cl_col_nxt = 8'd0;
          cl_pg_nxt  = '0;
          rd_nxt     = 8'h00;
          unique case (in_command)
            gtf_pkg::CMD_CLEAR: begin
              if (vis_w == 8'd0 || vis_p == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_CLEAR;
              end
            end
            gtf_pkg::CMD_PIXEL, gtf_pkg::CMD_GLYPH: begin
              state_nxt = ST_GSEL;
            end
            gtf_pkg::CMD_TEXT: begin
              // A string start reloads the cursor and revives a dropped string.
              if (in_text_start) begin
                dropped_nxt = 1'b0;
                state_nxt   = ST_GSEL;
              end else begin
                x_nxt     = cursor_x_r;
                y_nxt     = cursor_y_r;
                state_nxt = dropped_r ? ST_DONE : ST_GSEL;
              end
            end
            gtf_pkg::CMD_READ: begin
              ram_re    = rd_in_range;
              ram_raddr = gtf_pkg::fb_addr(6'(in_read_page), 8'(in_read_column));
              state_nxt = rd_in_range ? ST_RDD : ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = gtf_pkg::fb_addr(6'(cl_pg_r), cl_col_r);
        if ((cl_col_r + 8'd1) == vis_w) begin
          cl_col_nxt = 8'd0;
          cl_pg_nxt  = cl_pg_r + 1'b1;
          if ((cl_pg_r + 1'b1) == vis_p) begin
            state_nxt = ST_DONE;
          end
        end else begin
          cl_col_nxt = cl_col_r + 8'd1;
        end
      end

      ST_GSEL: begin
        if (g_vis) begin
          ram_re    = 1'b1;
          ram_raddr = g_addr;
          addr_nxt  = g_addr;
          mask_nxt  = g_mask;
          state_nxt = ST_GWR;
        end else if (g_last) begin
          state_nxt = ST_DONE;
        end else if (half_r) begin
          col_nxt  = col_r + 3'd1;
          half_nxt = 1'b0;
        end else begin
          half_nxt = 1'b1;
        end
      end

      ST_GWR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = on_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
        if (g_last) begin
          state_nxt = ST_DONE;
        end else if (half_r) begin
          col_nxt   = col_r + 3'd1;
          half_nxt  = 1'b0;
          state_nxt = ST_GSEL;
        end else begin
          half_nxt  = 1'b1;
          state_nxt = ST_GSEL;
        end
      end

      ST_RDD: begin
        rd_nxt    = ram_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // A drawn text character moves the cursor; the string is dropped once
        // the next character would reach the last visible row of the area.
        if (cmd_r == gtf_pkg::CMD_TEXT && !dropped_r) begin
          cursor_x_nxt = t_wrap ? 8'd0 : t_nx;
          cursor_y_nxt = t_ny;
          dropped_nxt  = (10'(t_ny) + 10'd7) >= 10'({vis_p, 3'b000});
        end
        out_valid_nxt        = 1'b1;
        out_read_data_nxt    = rd_r;
        out_text_stopped_nxt = dropped_nxt;
        state_nxt            = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_INIT;
      width_r            <= 8'(gtf_pkg::MAX_WIDTH);
      height_r           <= 4'd8;
      cursor_x_r         <= 8'd0;
      cursor_y_r         <= 8'd0;
      dropped_r          <= 1'b0;
      init_addr_r        <= '0;
      out_valid_r        <= 1'b0;
      out_read_data_r    <= 8'h00;
      out_text_stopped_r <= 1'b0;
    end else begin
      state_r            <= state_nxt;
      width_r            <= width_nxt;
      height_r           <= height_nxt;
      cursor_x_r         <= cursor_x_nxt;
      cursor_y_r         <= cursor_y_nxt;
      dropped_r          <= dropped_nxt;
      init_addr_r        <= init_addr_nxt;
      out_valid_r        <= out_valid_nxt;
      out_read_data_r    <= out_read_data_nxt;
      out_text_stopped_r <= out_text_stopped_nxt;
    end
  end

  // Working registers of the current transaction need no reset.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    code_r   <= code_nxt;
    on_r     <= on_nxt;
    pix_r    <= pix_nxt;
    col_r    <= col_nxt;
    half_r   <= half_nxt;
    mask_r   <= mask_nxt;
    addr_r   <= addr_nxt;
    cl_col_r <= cl_col_nxt;
    cl_pg_r  <= cl_pg_nxt;
    rd_r     <= rd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_text_stopped = out_text_stopped_r;

endmodule

`default_nettype wire

[src/gtf_checker.sv]
// Port-level checks for the glyph text framebuffer and the bind that attaches
// them to glyph_text_framebuffer_unit. No package dependencies.
`default_nettype none

module gtf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result appears only as the block returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a transaction");

endmodule

bind glyph_text_framebuffer_unit gtf_checker u_gtf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);

`default_nettype wire
